### sv/jls_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi solver package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package jls_pkg;

  localparam int unsigned DefMaxN      = 64;
  localparam int unsigned DefMaxSweeps = 1024;

  // Payload widths fixed by the stream formats.
  localparam int unsigned RowW      = 6;
  localparam int unsigned ValW      = 32;
  localparam int unsigned SweepOutW = 11;
  localparam int unsigned CfgDataW  = 31;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 56;

  // Configuration register indexes.
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_SIZE_USED = 1'b1;

  localparam logic [CfgDataW-1:0] TolReset  = CfgDataW'(66);
  localparam logic [SizeW-1:0]    SizeReset = SizeW'(64);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_START,
    ST_ROW_INIT,
    ST_MAC,
    ST_DRAIN,
    ST_CLAMP,
    ST_DIV,
    ST_FIN,
    ST_DIFF,
    ST_UPD,
    ST_SWEEP_END,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } jls_state_e;

endpackage

### sv/jacobi_linear_solver.sv
// ----------------------------------------------------------------------------
// Jacobi linear solver
// Loads A and b in Q16.16, runs Jacobi sweeps and streams out the solution.
// ----------------------------------------------------------------------------
// Usage and timing: the slave stream loads one element of A or b per cycle
// while the block is idle. An element with tlast set is stored and then starts
// a solve, during which tready stays low. Each sweep walks the rows one by
// one through a single multiply-accumulate pipe and one shared radix-2 divider:
// a row goes through setup, multiply-accumulate issue for each of its n
// columns, a pipe drain, 64 divider steps and then bookkeeping (a zero diagonal
// skips the divider and its finishing step), and a solve repeats the sweep
// until it converges or reaches the sweep limit. The result is then sent as n
// requests on the master stream, each sent only once the sink has taken the
// one before, after which the block takes new elements again. The solution
// vector ping-pongs between two banks of one memory, so no copy is needed
// between sweeps. The stores keep their contents between solves; only the x
// vector restarts from zero.
module jacobi_linear_solver
  import jls_pkg::*;
#(
  parameter int unsigned MAX_N      = DefMaxN,
  parameter int unsigned MAX_SWEEPS = DefMaxSweeps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Load stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // row[5:0], col[11:6], value[43:12]
  input  logic                s_axis_tuser,   // req_type[0]
  input  logic                s_axis_tlast,   // start_req
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // index[5:0], x_value[37:6], sweeps[48:38]
  output logic [1:0]          m_axis_tuser,   // converged[0], diag_zero[1]
  output logic                m_axis_tlast    // last
);

  localparam int unsigned IW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned AW  = $clog2(MAX_N * MAX_N);
  localparam int unsigned XAW = IW + 1;
  localparam int unsigned SW  = $clog2(MAX_SWEEPS + 1);
  localparam int unsigned NLim = (MAX_N < 64) ? MAX_N : 64;
  localparam int unsigned AccW = 56;
  localparam logic signed [AccW-1:0] AccLim = AccW'(64'sd140737488355327);

  // Configuration registers.
  logic [CfgDataW-1:0] tol_q;
  logic [SizeW-1:0]    size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TolReset;
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOLERANCE: tol_q  <= cfg_data_i;
        REG_SIZE_USED: size_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Effective size: zero is taken as one, large values are clipped.
  logic [CW-1:0] n_w;
  always_comb begin
    if (size_q == '0) begin
      n_w = CW'(1);
    end else if (32'(size_q) > NLim) begin
      n_w = CW'(NLim);
    end else begin
      n_w = CW'(size_q);
    end
  end

  // Input fields.
  logic [RowW-1:0] in_row, in_col;
  logic [ValW-1:0] in_val;
  logic            s_acc;
  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[43:12];
  assign s_acc  = s_axis_tvalid && s_axis_tready;

  logic          row_ok, col_ok;
  logic [AW-1:0] wr_addr;
  assign row_ok  = 32'(in_row) < MAX_N;
  assign col_ok  = 32'(in_col) < MAX_N;
  assign wr_addr = AW'(in_row) * AW'(MAX_N) + AW'(in_col);

  // Sequencer registers.
  jls_state_e state_q, state_d;
  logic [CW-1:0] i_q, j_q;
  logic [AW-1:0] base_q;
  logic          cur_q;      // bank being written this sweep
  logic          first_q;    // first sweep: previous vector is zero
  logic [SW-1:0] cnt_q;
  logic [31:0]   max_q;
  logic          conv_q, dz_q;

  // Memories.
  logic [ValW-1:0] coef_mem [MAX_N*MAX_N];
  logic [ValW-1:0] rhs_mem  [MAX_N];
  logic [ValW-1:0] x_mem    [2**XAW];
  logic [ValW-1:0] coef_rd_q, rhs_rd_q, x_rd_q;
  logic [XAW-1:0]  x_raddr;
  logic            x_we;
  logic [ValW-1:0] q_q;

  always_ff @(posedge clk_i) begin
    if (s_acc && !s_axis_tuser && row_ok && col_ok) begin
      coef_mem[wr_addr] <= in_val;
    end
    if (s_acc && s_axis_tuser && row_ok) begin
      rhs_mem[IW'(in_row)] <= in_val;
    end
    coef_rd_q <= coef_mem[base_q + AW'(j_q)];
    rhs_rd_q  <= rhs_mem[i_q[IW-1:0]];
  end

  always_comb begin
    unique case (state_q)
      ST_MAC:                             x_raddr = {~cur_q, j_q[IW-1:0]};
      ST_OUT_RD, ST_OUT_LOAD, ST_OUT_WAIT: x_raddr = {cur_q, i_q[IW-1:0]};
      default:                            x_raddr = {~cur_q, i_q[IW-1:0]};
    endcase
  end
  assign x_we = (state_q == ST_DIFF);

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[{cur_q, i_q[IW-1:0]}] <= q_q;
    end
    x_rd_q <= x_mem[x_raddr];
  end

  // Multiply-accumulate pipe: issue, product, accumulate.
  logic                   s1_v_q, s2_v_q, s2_diag_q;
  logic [CW-1:0]          s1_j_q;
  logic signed [63:0]     prod_q;
  logic signed [63:0]     prod_sh;
  logic signed [AccW-1:0] acc_q;
  logic [ValW-1:0]        diag_q;
  logic signed [ValW-1:0] xold;
  assign xold    = first_q ? '0 : $signed(x_rd_q);
  assign prod_sh = prod_q >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= (state_q == ST_MAC);
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_j_q    <= j_q;
    s2_diag_q <= (s1_j_q == i_q);
    prod_q    <= $signed(coef_rd_q) * xold;
    if (s1_v_q && s1_j_q == i_q) begin
      diag_q <= coef_rd_q;
    end
    if (state_q == ST_ROW_INIT) begin
      acc_q <= AccW'($signed(rhs_rd_q)) <<< 16;
    end else if (s2_v_q && !s2_diag_q) begin
      acc_q <= acc_q - AccW'(prod_sh);
    end
  end

  // Shared restoring divider on magnitudes.
  logic [63:0] dvd_q;
  logic [31:0] dvs_q, rem_q;
  logic        neg_q;
  logic [6:0]  dcnt_q;
  logic [32:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, dvd_q[63]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  logic signed [AccW-1:0] acc_c;
  logic [AccW-1:0]        acc_mag;
  always_comb begin
    if (acc_q > AccLim) begin
      acc_c = AccLim;
    end else if (acc_q < -AccLim) begin
      acc_c = -AccLim;
    end else begin
      acc_c = acc_q;
    end
    acc_mag = acc_c[AccW-1] ? AccW'(-acc_c) : AccW'(acc_c);
  end

  logic signed [33:0] diff_s;
  logic [31:0]        diff_q;
  assign diff_s = 34'($signed(q_q)) - 34'(xold);

  logic [SW-1:0] cnt_nxt;
  assign cnt_nxt = cnt_q + SW'(1);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CLAMP: begin
        dvd_q  <= {acc_mag[47:0], 16'b0};
        dvs_q  <= diag_q[31] ? 32'(-$signed(diag_q)) : diag_q;
        neg_q  <= acc_c[AccW-1] ^ diag_q[31];
        rem_q  <= '0;
        dcnt_q <= '0;
        if (diag_q == '0) begin
          q_q <= acc_c[AccW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
        dvd_q  <= {dvd_q[62:0], rem_ge};
        dcnt_q <= dcnt_q + 7'd1;
      end
      ST_FIN: begin
        if (neg_q) begin
          q_q <= (dvd_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-dvd_q);
        end else begin
          q_q <= (dvd_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
        end
      end
      ST_DIFF: begin
        diff_q <= diff_s[33] ? 32'(-diff_s) : diff_s[31:0];
      end
      default: ;
    endcase
  end

  // Output register.
  logic [OutDataW-1:0] od_q;
  logic [1:0]          ou_q;
  logic                ol_q, ov_q;
  logic [31:0]         cnt_ext;
  logic [SweepOutW-1:0] sw_out;
  assign cnt_ext = 32'(cnt_q);
  assign sw_out  = (cnt_ext > 32'd2047) ? SweepOutW'(2047) : cnt_ext[SweepOutW-1:0];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (s_acc && s_axis_tlast) state_d = ST_ROW_START;
      ST_ROW_START: state_d = ST_ROW_INIT;
      ST_ROW_INIT:  state_d = ST_MAC;
      ST_MAC:       if (j_q == n_w - CW'(1)) state_d = ST_DRAIN;
      ST_DRAIN:     if (!s1_v_q && !s2_v_q) state_d = ST_CLAMP;
      ST_CLAMP:     state_d = (diag_q == '0) ? ST_DIFF : ST_DIV;
      ST_DIV:       if (dcnt_q == 7'd63) state_d = ST_FIN;
      ST_FIN:       state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_UPD;
      ST_UPD:       state_d = (i_q == n_w - CW'(1)) ? ST_SWEEP_END : ST_ROW_START;
      ST_SWEEP_END: begin
        if (max_q < {1'b0, tol_q} || cnt_nxt == SW'(MAX_SWEEPS)) begin
          state_d = ST_OUT_RD;
        end else begin
          state_d = ST_ROW_START;
        end
      end
      ST_OUT_RD:    state_d = ST_OUT_LOAD;
      ST_OUT_LOAD:  state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (m_axis_tready) begin
          state_d = ol_q ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      base_q  <= '0;
      cur_q   <= 1'b0;
      first_q <= 1'b1;
      cnt_q   <= '0;
      max_q   <= '0;
      conv_q  <= 1'b0;
      dz_q    <= 1'b0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          i_q     <= '0;
          base_q  <= '0;
          first_q <= 1'b1;
          cnt_q   <= '0;
          max_q   <= '0;
          conv_q  <= 1'b0;
          dz_q    <= 1'b0;
        end
        ST_ROW_START: j_q <= '0;
        ST_MAC:       j_q <= j_q + CW'(1);
        ST_CLAMP:     if (diag_q == '0) dz_q <= 1'b1;
        ST_UPD: begin
          if (diff_q > max_q) max_q <= diff_q;
          if (i_q != n_w - CW'(1)) begin
            i_q    <= i_q + CW'(1);
            base_q <= base_q + AW'(MAX_N);
          end
        end
        ST_SWEEP_END: begin
          cnt_q  <= cnt_nxt;
          i_q    <= '0;
          base_q <= '0;
          if (max_q < {1'b0, tol_q}) begin
            conv_q <= 1'b1;
          end else if (cnt_nxt != SW'(MAX_SWEEPS)) begin
            cur_q   <= ~cur_q;
            first_q <= 1'b0;
            max_q   <= '0;
          end
        end
        ST_OUT_LOAD: begin
          ov_q <= 1'b1;
          ol_q <= (i_q == n_w - CW'(1));
        end
        ST_OUT_WAIT: begin
          if (m_axis_tready) begin
            ov_q <= 1'b0;
            i_q  <= i_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT_LOAD) begin
      od_q <= {7'b0, sw_out, x_rd_q, 6'(i_q)};
      ou_q <= {dz_q, conv_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

endmodule

### sv/jls_checker.sv
// ----------------------------------------------------------------------------
// Jacobi solver port checker
// Watches the stream ports of the solver and flags illegal sequences.
// ----------------------------------------------------------------------------
module jls_checker
  import jls_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("load side ready while a result is pending");

  // A starting element closes the load side.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("load side still ready after a start request");

  // After the final result the block is ready to load again.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("load side not reopened after the final result");

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind jacobi_linear_solver jls_checker u_jls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jacobi solver testbench
// Loads small linear systems over the load stream, predicts every solution
// element with an in-bench fixed-point Jacobi solver and checks the result
// stream field by field under random idling.
// ----------------------------------------------------------------------------
module tb;
  import jls_pkg::*;

  // One load request as it travels on the slave stream.
  typedef struct packed {
    logic        rhs;       // 0 coefficient, 1 right-hand side
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    logic        start;
  } load_req_t;

  // One solution element as it is expected on the master stream.
  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] x_value;
    logic        converged;
    logic [10:0] sweeps;
    logic        diag_zero;
    logic        last;
  } solution_t;

  localparam int unsigned WatchLimit = 1500000;
  localparam int unsigned IdleGap    = 40;
  localparam longint      AccLimit   = 64'sd140737488355327;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = REG_TOLERANCE;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  jacobi_linear_solver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's registers and stores, updated as requests are taken.
  logic [30:0]        tol_reg = 31'd66;
  logic [6:0]         size_reg = 7'd64;
  logic signed [31:0] coef_mem [64][64];
  logic signed [31:0] rhs_mem [64];

  load_req_t load_q[$];
  solution_t solution_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_cycles = 0;
  bit          hold_req = 1'b0;
  bit          in_took = 1'b0;
  int unsigned errors = 0;
  int unsigned reqs_taken = 0;
  int unsigned solves = 0;
  int unsigned elems_seen = 0;
  int unsigned quiet = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Fixed-point Jacobi solve on the shadow stores. Products are floored to
  // Q16.16, the row sum is clamped, and the quotient truncates and saturates.
  task automatic predict_solution();
    int          n, s, sw;
    longint      acc, d, q, diff, mc;
    longint      xp[64];
    longint      xn[64];
    bit          conv, dz;
    solution_t   r;
    n = (size_reg == 0) ? 1 : (size_reg > 64) ? 64 : int'(size_reg);
    conv = 0;
    dz = 0;
    sw = 0;
    for (int i = 0; i < 64; i++) begin
      xp[i] = 0;
      xn[i] = 0;
    end
    for (s = 1; s <= DefMaxSweeps; s++) begin
      mc = 0;
      for (int i = 0; i < n; i++) begin
        acc = longint'(rhs_mem[i]) * 65536;
        for (int j = 0; j < n; j++)
          if (j != i) acc -= (longint'(coef_mem[i][j]) * xp[j]) >>> 16;
        if (acc > AccLimit) acc = AccLimit;
        if (acc < -AccLimit) acc = -AccLimit;
        d = longint'(coef_mem[i][i]);
        if (d == 0) begin
          dz = 1;
          q = (acc >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
          q = (acc * 65536) / d;
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
        end
        xn[i] = q;
        diff = q - xp[i];
        if (diff < 0) diff = -diff;
        if (diff > 64'sd4294967295) diff = 64'sd4294967295;
        if (diff > mc) mc = diff;
      end
      sw = s;
      if (mc < longint'(tol_reg)) begin
        conv = 1;
        break;
      end
      for (int i = 0; i < n; i++) xp[i] = xn[i];
    end
    for (int i = 0; i < n; i++) begin
      r.index     = 6'(i);
      r.x_value   = 32'(xn[i]);
      r.converged = conv;
      r.sweeps    = 11'(sw);
      r.diag_zero = dz;
      r.last      = (i == n - 1);
      solution_q.push_back(r);
    end
    solves++;
  endtask

  // Input side: take requests at the rising edge, update the shadow stores.
  always @(posedge clk_i) begin
    in_took = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_took) begin
      reqs_taken++;
      if (s_axis_tuser)
        rhs_mem[s_axis_tdata[5:0]] = s_axis_tdata[43:12];
      else
        coef_mem[s_axis_tdata[5:0]][s_axis_tdata[11:6]] = s_axis_tdata[43:12];
      if (s_axis_tlast) predict_solution();
    end
  end

  // Driver: presents the next pending request at the falling edge. A held
  // request stays put until taken.
  always @(negedge clk_i) begin
    if (rst_ni && (in_took || !s_axis_tvalid)) begin
      if (load_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        load_req_t r;
        r = load_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, r.value, r.col, r.row};
        s_axis_tuser  <= r.rhs;
        s_axis_tlast  <= r.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stalls, or a long counted hold-off when one is requested.
  // The hold-off starts once a result is waiting, so the input backs up.
  always @(negedge clk_i) begin
    if (hold_req && hold_cycles == 0 && m_axis_tvalid) begin
      hold_cycles = 400;
      hold_req = 1'b0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: each solution element against the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      solution_t w;
      elems_seen++;
      if (solution_q.size() == 0) begin
        report("unexpected element", m_axis_tdata, 0);
      end else begin
        w = solution_q.pop_front();
        if (m_axis_tdata[5:0] !== w.index) report("index", m_axis_tdata[5:0], w.index);
        if (m_axis_tdata[37:6] !== w.x_value) report("x_value", m_axis_tdata[37:6], w.x_value);
        if (m_axis_tdata[48:38] !== w.sweeps) report("sweeps", m_axis_tdata[48:38], w.sweeps);
        if (m_axis_tuser[0] !== w.converged)
          report("converged", m_axis_tuser[0], w.converged);
        if (m_axis_tuser[1] !== w.diag_zero)
          report("diag_zero", m_axis_tuser[1], w.diag_zero);
        if (m_axis_tlast !== w.last) report("last", m_axis_tlast, w.last);
      end
    end
  end

  // Watchdog: a long solve is quiet, but never for this long.
  always @(posedge clk_i) begin
    if ((rst_ni && s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WatchLimit) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic add_req(input logic rhs, input int row, input int col,
                         input logic [31:0] value, input logic start);
    load_req_t r;
    r.rhs = rhs;
    r.row = 6'(row);
    r.col = 6'(col);
    r.value = value;
    r.start = start;
    load_q.push_back(r);
  endtask

  // Block until nothing is pending or expected, plus a margin for the block
  // to finish its last handshake and return to idle.
  task automatic wait_idle();
    while (load_q.size() > 0 || s_axis_tvalid || solution_q.size() > 0)
      @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TOLERANCE) tol_reg = data;
    else size_reg = data[6:0];
  endtask

  // Queue a full system of n unknowns. Well-conditioned systems are strongly
  // diagonally dominant; wild ones take any 32-bit values. The element that
  // carries the start flag is picked at random.
  task automatic add_system(input int n, input bit wild);
    load_req_t sys[$];
    load_req_t r;
    int        k;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        r.rhs = 1'b0;
        r.row = 6'(i);
        r.col = 6'(j);
        if (wild) r.value = $urandom;
        else if (i == j)
          r.value = ($urandom_range(1) ? 32'h0 - $urandom_range(32'h80000, 32'h40000)
                                       : $urandom_range(32'h80000, 32'h40000));
        else r.value = $urandom_range(32'h8000) - 32'h4000;
        r.start = 1'b0;
        sys.push_back(r);
      end
      r.rhs = 1'b1;
      r.row = 6'(i);
      r.col = 6'($urandom_range(63));
      r.value = wild ? $urandom : ($urandom_range(32'h200000) - 32'h100000);
      r.start = 1'b0;
      sys.push_back(r);
    end
    k = $urandom_range(sys.size() - 1);
    r = sys[k];
    sys.delete(k);
    r.start = 1'b1;
    sys.push_back(r);
    foreach (sys[i]) load_q.push_back(sys[i]);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned random_reqs;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one unknown with a zero tolerance never converges and runs
    // the full sweep limit.
    write_reg(REG_SIZE_USED, 31'd1);
    write_reg(REG_TOLERANCE, 31'd0);
    add_req(1'b0, 0, 0, 32'h0001_0000, 1'b0);
    add_req(1'b1, 0, 0, 32'h7FFF_FFFF, 1'b1);
    wait_idle();

    // Zero diagonal with a negative, then a zero right-hand side.
    write_reg(REG_TOLERANCE, 31'd66);
    add_req(1'b0, 0, 0, 32'h0, 1'b0);
    add_req(1'b1, 0, 63, 32'h8000_0000, 1'b1);
    add_req(1'b1, 0, 0, 32'h0, 1'b0);
    add_req(1'b0, 0, 0, 32'h0, 1'b1);
    wait_idle();

    // A size of zero is taken as one.
    write_reg(REG_SIZE_USED, 31'd0);
    add_req(1'b0, 0, 0, 32'h0003_0000, 1'b1);
    wait_idle();

    // Two unknowns with extreme coefficients: saturation, likely no
    // convergence.
    write_reg(REG_SIZE_USED, 31'd2);
    add_req(1'b0, 0, 0, 32'h8000_0000, 1'b0);
    add_req(1'b0, 0, 1, 32'h7FFF_FFFF, 1'b0);
    add_req(1'b0, 1, 0, 32'h0000_0001, 1'b0);
    add_req(1'b0, 1, 1, 32'h7FFF_FFFF, 1'b0);
    add_req(1'b1, 0, 0, 32'h7FFF_FFFF, 1'b0);
    add_req(1'b1, 1, 0, 32'h8000_0000, 1'b1);
    wait_idle();

    // Random systems, the idling profile changing from one to the next.
    phase = 0;
    random_reqs = 0;
    n = 2;
    while (random_reqs < 180) begin
      if (phase == 0 || $urandom_range(2) != 0) begin
        wait_idle();
        n = ($urandom_range(7) == 0) ? 1 : $urandom_range(4, 2);
        write_reg(REG_SIZE_USED, 31'(n));
        write_reg(REG_TOLERANCE,
                  31'($urandom_range(7) == 0 ? $urandom : $urandom_range(4096, 1)));
      end
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      // Stray writes outside the system between solves.
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) begin
          add_req(1'($urandom), $urandom_range(63, 4), $urandom_range(63), $urandom, 1'b0);
          random_reqs++;
        end
      add_system(n, n <= 2 && $urandom_range(5) == 0);
      random_reqs += n * n + n;
      // Once: hold the sink off so the next system backs up at the input.
      if (phase == 1) begin
        hold_req = 1'b1;
        add_system(n, 1'b0);
        random_reqs += n * n + n;
      end
      phase++;
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    $display("Took %0d load requests and ran %0d solves, sizes 0 to 4 requested.",
             reqs_taken, solves);
    $display("Checked %0d solution elements with %0d mismatches.", elems_seen, errors);
    if (errors == 0 && solution_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
